// ===== hdl/btoc_pkg.sv =====
`default_nettype none
package btoc_pkg;

  // default limits of the top level
  localparam int MAX_IMAGE_SIDE_DEF   = 1024;
  localparam int MAX_TILE_COLUMNS_DEF = 512;

  // register widths and reset values
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] TILE_SIZE_RESET  = 11'd500;
  localparam logic [CFG_W-1:0] IMAGE_SIDE_RESET = 11'd500;
  localparam int MIN_TILE = 2;

  // result field widths
  localparam int CENTER_W = 10;
  localparam int GOAL_W   = 18;

  // occupied flags are kept in memory rows of this many bits
  localparam int FLAG_ROW_BITS = 8;

  // register map, word index
  typedef enum logic [1:0] {
    REG_TILE_SIZE    = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_t;

  // control from the pipeline to the flag store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } flag_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/btoc_flag_store.sv =====
`default_nettype none
module btoc_flag_store #(
  parameter int COLS = btoc_pkg::MAX_TILE_COLUMNS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire btoc_pkg::flag_ctl_t      ctl,
  input  wire logic [$clog2(COLS)-1:0]  rd_idx,
  input  wire logic [$clog2(COLS)-1:0]  cur_idx,
  input  wire logic                     wr_occ,
  output logic                          flag
);

  localparam int RB   = btoc_pkg::FLAG_ROW_BITS;
  localparam int RL   = $clog2(RB);
  localparam int ROWS = (COLS + RB - 1) / RB;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW   = $clog2(COLS);

  logic [IW+RL-1:0] rd_ext;
  logic [IW+RL-1:0] cur_ext;
  logic [RAW-1:0]   rd_row;
  logic [RAW-1:0]   cur_row;
  logic [RL-1:0]    cur_pos;

  logic [RB-1:0]    mem [ROWS];
  logic [RB-1:0]    rd_q;
  logic [ROWS-1:0]  row_valid;
  logic [RAW-1:0]   byp_row;
  logic [RB-1:0]    byp_data;
  logic [RB-1:0]    row_data;
  logic [RB-1:0]    wr_data;

  assign rd_ext  = {{RL{1'b0}}, rd_idx};
  assign cur_ext = {{RL{1'b0}}, cur_idx};
  assign rd_row  = rd_ext[RAW+RL-1:RL];
  assign cur_row = cur_ext[RAW+RL-1:RL];
  assign cur_pos = cur_ext[RL-1:0];

  // a row not written since the last clear reads as all zero;
  // the latest write overrides the registered read
  always_comb begin
    if (!row_valid[cur_row]) begin
      row_data = '0;
    end else if (byp_row == cur_row) begin
      row_data = byp_data;
    end else begin
      row_data = rd_q;
    end
    wr_data          = row_data;
    wr_data[cur_pos] = wr_occ;
  end

  assign flag = row_data[cur_pos];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[cur_row] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      byp_row  <= cur_row;
      byp_data <= wr_data;
    end
  end

  // clear wins over a write at the same edge
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      row_valid <= '0;
    end else if (ctl.wr_en) begin
      row_valid[cur_row] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/binary_tile_occupancy_centers.sv =====
`default_nettype none
// channel   direction  handshake                fields
// s_*       in         s_tvalid / s_tready      tdata: pixel[7:0]; tuser: frame_start[0]
// m_*       out        m_tvalid / m_tready      tdata: center_x[9:0] center_y[19:10]
//                                               goal_index[37:20]
// apb       in         psel penable pwrite      tile_size 0x0, image_width 0x4,
//                                               image_height 0x8
//
// one pixel per clock while s_tready is high; the tile logic and the flag
// memory read go into the stage register, and a result moves from there
// into the output register unless the output is stalled
// the occupied flags sit in a memory with one registered read port; row valid
// flops clear the whole store at frame start or frame end
// s_tready drops only while a result waits in the output register and the
// next result behind it is ready to go
// reset is synchronous; registers return to 500/500/500, counters to zero
module binary_tile_occupancy_centers #(
  parameter int MAX_IMAGE_SIDE   = btoc_pkg::MAX_IMAGE_SIDE_DEF,
  parameter int MAX_TILE_COLUMNS = btoc_pkg::MAX_TILE_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // pixel stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel
  input  wire logic [0:0]  s_tuser,   // [0] frame_start
  // goal stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [9:0] center_x, [19:10] center_y, [37:20] goal_index
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int P    = $clog2(MAX_IMAGE_SIDE);         // position width
  localparam int SW   = P + 2;                          // sums of position and tile size
  localparam int CW   = (P + 1 > btoc_pkg::CFG_W) ? P + 1 : btoc_pkg::CFG_W;
  localparam int TC_W = $clog2(MAX_TILE_COLUMNS + 1);   // tile column counter
  localparam int CI_W = $clog2(MAX_TILE_COLUMNS);       // flag index
  localparam int CTR  = btoc_pkg::CENTER_W;
  localparam int GW   = btoc_pkg::GOAL_W;
  localparam int CFW  = btoc_pkg::CFG_W;

  localparam logic [CW-1:0]   MAX_SIDE_C = CW'(MAX_IMAGE_SIDE);
  localparam logic [CW-1:0]   MIN_TILE_C = CW'(btoc_pkg::MIN_TILE);
  localparam logic [TC_W-1:0] MAX_TC_C   = TC_W'(MAX_TILE_COLUMNS);

  // ---------------------------------------------------------------- registers
  logic [CFW-1:0] tile_size;
  logic [CFW-1:0] image_width;
  logic [CFW-1:0] image_height;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size    <= btoc_pkg::TILE_SIZE_RESET;
      image_width  <= btoc_pkg::IMAGE_SIDE_RESET;
      image_height <= btoc_pkg::IMAGE_SIDE_RESET;
    end else if (cfg_wr) begin
      case (btoc_pkg::reg_idx_t'(paddr[3:2]))
        btoc_pkg::REG_TILE_SIZE:    tile_size    <= pwdata[CFW-1:0];
        btoc_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[CFW-1:0];
        btoc_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[CFW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (btoc_pkg::reg_idx_t'(paddr[3:2]))
      btoc_pkg::REG_TILE_SIZE:    prdata = {{(32-CFW){1'b0}}, tile_size};
      btoc_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-CFW){1'b0}}, image_width};
      btoc_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-CFW){1'b0}}, image_height};
      default:                    prdata = '0;
    endcase
  end

  // clamped sizes: tile size at least 2, image sides at least 1, all at most
  // the largest image side
  logic [CW-1:0] ts_ext, iw_ext, ih_ext;
  logic [CW-1:0] k_c, w_c, h_c;
  logic [SW-1:0] k, w, h;

  always_comb begin
    ts_ext = CW'(tile_size);
    iw_ext = CW'(image_width);
    ih_ext = CW'(image_height);
    if (ts_ext < MIN_TILE_C)       k_c = MIN_TILE_C;
    else if (ts_ext > MAX_SIDE_C)  k_c = MAX_SIDE_C;
    else                           k_c = ts_ext;
    if (iw_ext == '0)              w_c = CW'(1);
    else if (iw_ext > MAX_SIDE_C)  w_c = MAX_SIDE_C;
    else                           w_c = iw_ext;
    if (ih_ext == '0)              h_c = CW'(1);
    else if (ih_ext > MAX_SIDE_C)  h_c = MAX_SIDE_C;
    else                           h_c = ih_ext;
    k = {1'b0, k_c[P:0]};
    w = {1'b0, w_c[P:0]};
    h = {1'b0, h_c[P:0]};
  end

  // ---------------------------------------------------------- raster state
  logic [P-1:0]    col_pos, row_pos, col_in, row_in, tile_org;
  logic [TC_W-1:0] tcol;
  logic [P-1:0]    col_pos_next, row_pos_next, col_in_next, row_in_next, tile_org_next;
  logic [TC_W-1:0] tcol_next;

  // values after a frame start restart, before this pixel is taken
  logic [P-1:0]    cp, rp, ci, ri, to;
  logic [TC_W-1:0] tc;

  logic            acc;
  logic            sof;
  logic [P-1:0]    origin_x;
  logic [SW-1:0]   ox_end, oy_end, ci_inc, ri_inc, cp_inc, rp_inc;
  logic [SW-1:0]   cx_full, cy_full;
  logic [SW+CTR-1:0] cx_wide, cy_wide;
  logic            elig, fresh, last, eof;

  assign acc = s_tvalid && s_tready;
  assign sof = s_tuser[0];

  always_comb begin
    if (sof) begin
      cp = '0; rp = '0; ci = '0; ri = '0; to = '0; tc = '0;
    end else begin
      cp = col_pos; rp = row_pos; ci = col_in; ri = row_in; to = tile_org; tc = tcol;
    end

    origin_x = cp - ci;
    ox_end   = SW'(origin_x) + k;
    oy_end   = SW'(to) + k;
    ci_inc   = SW'(ci) + SW'(1);
    ri_inc   = SW'(ri) + SW'(1);
    cp_inc   = SW'(cp) + SW'(1);
    rp_inc   = SW'(rp) + SW'(1);

    // only whole tiles inside the image and inside the flag store count
    elig  = (ox_end <= w) && (oy_end <= h) && (tc < MAX_TC_C);
    fresh = (ri == '0) && (ci == '0);
    last  = (ci_inc >= k) && (ri_inc >= k);

    cx_full = SW'(origin_x) + (k >> 1);
    cy_full = SW'(to) + (k >> 1);
    cx_wide = {{CTR{1'b0}}, cx_full};
    cy_wide = {{CTR{1'b0}}, cy_full};

    // advance the raster, wrapping on "reached or passed"
    eof           = 1'b0;
    col_pos_next  = cp;
    row_pos_next  = rp;
    col_in_next   = ci;
    row_in_next   = ri;
    tile_org_next = to;
    tcol_next     = tc;
    if (cp_inc >= w) begin
      col_pos_next = '0;
      col_in_next  = '0;
      tcol_next    = '0;
      if (rp_inc >= h) begin
        eof           = 1'b1;
        row_pos_next  = '0;
        row_in_next   = '0;
        tile_org_next = '0;
      end else begin
        row_pos_next = rp_inc[P-1:0];
        if (ri_inc >= k) begin
          row_in_next   = '0;
          tile_org_next = rp_inc[P-1:0];
        end else begin
          row_in_next = ri_inc[P-1:0];
        end
      end
    end else begin
      col_pos_next = cp_inc[P-1:0];
      if (ci_inc >= k) begin
        col_in_next = '0;
        if (tc < MAX_TC_C) begin
          tcol_next = tc + TC_W'(1);
        end
      end else begin
        col_in_next = ci_inc[P-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      col_in   <= '0;
      row_in   <= '0;
      tile_org <= '0;
      tcol     <= '0;
    end else if (acc) begin
      col_pos  <= col_pos_next;
      row_pos  <= row_pos_next;
      col_in   <= col_in_next;
      row_in   <= row_in_next;
      tile_org <= tile_org_next;
      tcol     <= tcol_next;
    end
  end

  // ------------------------------------------------------- flag stage (s1)
  logic             s1_v;
  logic [CI_W-1:0]  s1_idx;
  logic             s1_elig, s1_fresh, s1_last, s1_eof, s1_edge;
  logic [CTR-1:0]   s1_cx, s1_cy;
  logic             s1_adv;
  logic             s1_occ;
  logic             s1_emit;
  logic             stored;
  logic             clr;
  logic [GW-1:0]    goal_count;
  btoc_pkg::flag_ctl_t fctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (acc) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_idx   <= tc[CI_W-1:0];
      s1_elig  <= elig;
      s1_fresh <= fresh;
      s1_last  <= last;
      s1_eof   <= eof;
      s1_edge  <= (s_tdata != 8'd0);
      s1_cx    <= cx_wide[CTR-1:0];
      s1_cy    <= cy_wide[CTR-1:0];
    end
  end

  // the first pixel of a tile starts a fresh flag
  assign s1_occ  = s1_edge || (!s1_fresh && stored);
  assign s1_emit = s1_elig && s1_last && s1_occ;
  assign s1_adv  = s1_v && !(s1_emit && m_tvalid && !m_tready);
  assign s_tready = !s1_v || s1_adv;

  // a frame start clears behind the older pixel in s1; a frame end clears
  // behind the last pixel itself
  assign clr = (acc && sof) || (s1_adv && s1_eof);

  assign fctl.rd_en = acc;
  assign fctl.wr_en = s1_adv && s1_elig;
  assign fctl.clr   = clr;

  btoc_flag_store #(
    .COLS (MAX_TILE_COLUMNS)
  ) u_flags (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fctl),
    .rd_idx  (tc[CI_W-1:0]),
    .cur_idx (s1_idx),
    .wr_occ  (s1_occ),
    .flag    (stored)
  );

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      goal_count <= '0;
    end else if (s1_adv && s1_emit) begin
      goal_count <= goal_count + GW'(1);
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      m_tdata <= {2'b00, goal_count, s1_cy, s1_cx};
    end
  end

endmodule
`default_nettype wire
